>>> rtl/terq_pkg.sv
// ----------------------------------------------------------------------------
// terq_pkg
// Shared constants, codes, types and helpers of the timed event release queue.
// ----------------------------------------------------------------------------
package terq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int TAG_BITS    = 16;

  localparam int IDX_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int TIME_W    = 32;
  localparam int DELAY_W   = 24;
  localparam int TAG_PORT_W = 16;

  // free slot search: groups of eight valid bits
  localparam int GRP_SIZE = 8;
  localparam int GRP_N    = (QUEUE_DEPTH + GRP_SIZE - 1) / GRP_SIZE;

  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 2;

  // input action codes
  localparam logic [1:0] ACT_ENQUEUE = 2'd0;
  localparam logic [1:0] ACT_TICK    = 2'd1;
  localparam logic [1:0] ACT_CLEAR   = 2'd2;

  typedef enum logic [1:0] {
    CMD_ENQ,
    CMD_TICK,
    CMD_CLEAR,
    CMD_NOP
  } cmd_op_e;

  typedef enum logic [1:0] {
    ST_RELEASED = 2'd0,
    ST_ACCEPTED = 2'd1,
    ST_FULL     = 2'd2,
    ST_IDLE     = 2'd3
  } status_e;

  typedef struct packed {
    cmd_op_e              op;
    logic [DELAY_W-1:0]   delay;
    logic [TAG_BITS-1:0]  tag;
  } cmd_t;

  typedef struct packed {
    status_e               status;
    logic [TAG_PORT_W-1:0] tag;
    logic                  last;
  } res_t;

  // port tag -> stored tag (low TAG_BITS bits)
  function automatic logic [TAG_BITS-1:0] to_tag(input logic [TAG_PORT_W-1:0] x);
    logic [31:0] t;
    t = 32'(x);
    return t[TAG_BITS-1:0];
  endfunction

  // stored tag -> port tag
  function automatic logic [TAG_PORT_W-1:0] from_tag(input logic [TAG_BITS-1:0] x);
    logic [31:0] t;
    t = 32'(x);
    return t[TAG_PORT_W-1:0];
  endfunction

endpackage

>>> rtl/terq_front.sv
// ----------------------------------------------------------------------------
// terq_front
// Accepts input items, decodes the action and queues commands for the engine.
// ----------------------------------------------------------------------------
module terq_front import terq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  output logic                  full_o,
  input  logic [1:0]            action_i,
  input  logic [DELAY_W-1:0]    delay_ticks_i,
  input  logic [TAG_PORT_W-1:0] payload_tag_i,
  output logic                  cmd_valid_o,
  output cmd_t                  cmd_o,
  input  logic                  cmd_pop_i
);

  localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMD_DEPTH + 1);

  cmd_t             fifo_q [CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  cmd_t             cmd_in;
  logic             do_push, do_pop;

  always_comb begin
    cmd_in.delay = delay_ticks_i;
    cmd_in.tag   = to_tag(payload_tag_i);
    case (action_i)
      ACT_ENQUEUE: cmd_in.op = CMD_ENQ;
      ACT_TICK:    cmd_in.op = CMD_TICK;
      ACT_CLEAR:   cmd_in.op = CMD_CLEAR;
      default:     cmd_in.op = CMD_NOP;
    endcase
  end

  assign full_o      = (cnt_q == CNT_W'(CMD_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = fifo_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(CMD_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) fifo_q[wr_ptr_q] <= cmd_in;
  end

endmodule

>>> rtl/terq_engine.sv
// ----------------------------------------------------------------------------
// terq_engine
// Event store and sequencer: enqueue, clear, and tick release by scan passes.
// ----------------------------------------------------------------------------
module terq_engine import terq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  output logic res_push_o,
  output res_t res_o,
  input  logic res_full_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ_FIND,
    S_ENQ_PICK,
    S_SCAN,
    S_DRAIN,
    S_REPLY
  } state_e;

  typedef struct packed {
    logic [TIME_W-1:0]   due;
    logic [TIME_W-1:0]   order;
    logic [TAG_BITS-1:0] tag;
  } entry_t;

  state_e                 state_q;
  cmd_t                   cmd_q;
  logic [QUEUE_DEPTH-1:0] valid_q;
  logic [TIME_W-1:0]      cur_q, seq_q;
  logic [IDX_W-1:0]       scan_idx_q;

  // scan pipeline
  logic                s1_vld_q, s2_vld_q;
  logic [IDX_W-1:0]    s1_slot_q, s2_slot_q;
  entry_t              rdata_q;
  logic                s2_elig_q;
  logic [TIME_W-1:0]   s2_late_q, s2_age_q;
  logic [TAG_BITS-1:0] s2_tag_q;

  // best candidate of the current pass, and the release held back one pass
  logic                best_found_q;
  logic [TIME_W-1:0]   best_late_q, best_age_q;
  logic [TAG_BITS-1:0] best_tag_q;
  logic [IDX_W-1:0]    best_slot_q;
  logic                pend_q;
  logic [TAG_BITS-1:0] pend_tag_q;

  logic res_vld_q;
  res_t res_q;

  // free slot search registers
  logic       grp_any_q [GRP_N];
  logic [2:0] grp_low_q [GRP_N];
  logic       grp_any_d [GRP_N];
  logic [2:0] grp_low_d [GRP_N];
  logic [GRP_N*GRP_SIZE-1:0] valid_pad;

  logic             free_found;
  logic [IDX_W-1:0] free_slot;
  logic             res_free, better, flushed, mem_we;
  logic [TIME_W-1:0] late_d, age_d;
  logic             elig_d;
  entry_t           wentry;

  entry_t mem [QUEUE_DEPTH];

  assign cmd_pop_o  = (state_q == S_IDLE) && cmd_valid_i;
  assign res_push_o = res_vld_q;
  assign res_o      = res_q;
  assign res_free   = !res_vld_q || !res_full_i;
  assign flushed    = !s1_vld_q && !s2_vld_q;

  // group level free search (stage 1)
  always_comb begin
    valid_pad = '1;
    valid_pad[QUEUE_DEPTH-1:0] = valid_q;
    for (int g = 0; g < GRP_N; g++) begin
      grp_any_d[g] = 1'b0;
      grp_low_d[g] = '0;
      for (int b = GRP_SIZE - 1; b >= 0; b--) begin
        if (!valid_pad[g*GRP_SIZE + b]) begin
          grp_any_d[g] = 1'b1;
          grp_low_d[g] = 3'(b);
        end
      end
    end
  end

  // pick lowest group with a free slot (stage 2)
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int g = GRP_N - 1; g >= 0; g--) begin
      if (grp_any_q[g]) begin
        free_found = 1'b1;
        free_slot  = IDX_W'(g*GRP_SIZE + int'(grp_low_q[g]));
      end
    end
  end

  assign mem_we      = (state_q == S_ENQ_PICK) && res_free && free_found;
  assign wentry.due  = cur_q + TIME_W'(cmd_q.delay);
  assign wentry.order = seq_q;
  assign wentry.tag  = cmd_q.tag;

  // lateness and age of the entry just read
  assign late_d = cur_q - rdata_q.due;
  assign age_d  = seq_q - rdata_q.order;
  assign elig_d = s1_vld_q && valid_q[s1_slot_q] && !late_d[TIME_W-1];

  assign better = s2_vld_q && s2_elig_q &&
                  (!best_found_q || (s2_late_q > best_late_q) ||
                   ((s2_late_q == best_late_q) && (s2_age_q > best_age_q)));

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[free_slot] <= wentry;
    if (state_q == S_SCAN) rdata_q <= mem[scan_idx_q];
  end

  always_ff @(posedge clk_i) begin
    s1_slot_q <= scan_idx_q;
    s2_slot_q <= s1_slot_q;
    s2_elig_q <= elig_d;
    s2_late_q <= late_d;
    s2_age_q  <= age_d;
    s2_tag_q  <= rdata_q.tag;
    for (int g = 0; g < GRP_N; g++) begin
      grp_any_q[g] <= grp_any_d[g];
      grp_low_q[g] <= grp_low_d[g];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cmd_q        <= '0;
      valid_q      <= '0;
      cur_q        <= '0;
      seq_q        <= '0;
      scan_idx_q   <= '0;
      s1_vld_q     <= 1'b0;
      s2_vld_q     <= 1'b0;
      best_found_q <= 1'b0;
      best_late_q  <= '0;
      best_age_q   <= '0;
      best_tag_q   <= '0;
      best_slot_q  <= '0;
      pend_q       <= 1'b0;
      pend_tag_q   <= '0;
      res_vld_q    <= 1'b0;
      res_q        <= '0;
    end else begin
      s1_vld_q <= (state_q == S_SCAN);
      s2_vld_q <= s1_vld_q;
      if (res_vld_q && !res_full_i) res_vld_q <= 1'b0;
      if (better) begin
        best_found_q <= 1'b1;
        best_late_q  <= s2_late_q;
        best_age_q   <= s2_age_q;
        best_tag_q   <= s2_tag_q;
        best_slot_q  <= s2_slot_q;
      end

      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q <= cmd_i;
            case (cmd_i.op)
              CMD_ENQ: state_q <= S_ENQ_FIND;
              CMD_TICK: begin
                cur_q        <= cur_q + 1'b1;
                pend_q       <= 1'b0;
                best_found_q <= 1'b0;
                scan_idx_q   <= '0;
                state_q      <= S_SCAN;
              end
              CMD_CLEAR: begin
                valid_q <= '0;
                state_q <= S_REPLY;
              end
              default: state_q <= S_REPLY;
            endcase
          end
        end
        S_ENQ_FIND: state_q <= S_ENQ_PICK;
        S_ENQ_PICK: begin
          if (res_free) begin
            res_vld_q <= 1'b1;
            res_q     <= '{status: (free_found ? ST_ACCEPTED : ST_FULL),
                           tag: '0, last: 1'b1};
            if (free_found) begin
              valid_q[free_slot] <= 1'b1;
              seq_q              <= seq_q + 1'b1;
            end
            state_q <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (scan_idx_q == IDX_W'(QUEUE_DEPTH - 1)) state_q <= S_DRAIN;
          else scan_idx_q <= scan_idx_q + 1'b1;
        end
        S_DRAIN: begin
          if (flushed) begin
            if (best_found_q) begin
              // another entry due: the held release is not the last one
              if (!pend_q || res_free) begin
                if (pend_q) begin
                  res_vld_q <= 1'b1;
                  res_q     <= '{status: ST_RELEASED, tag: from_tag(pend_tag_q),
                                 last: 1'b0};
                end
                pend_q               <= 1'b1;
                pend_tag_q           <= best_tag_q;
                valid_q[best_slot_q] <= 1'b0;
                best_found_q         <= 1'b0;
                scan_idx_q           <= '0;
                state_q              <= S_SCAN;
              end
            end else if (res_free) begin
              res_vld_q <= 1'b1;
              if (pend_q) begin
                res_q <= '{status: ST_RELEASED, tag: from_tag(pend_tag_q), last: 1'b1};
              end else begin
                res_q <= '{status: ST_IDLE, tag: '0, last: 1'b1};
              end
              state_q <= S_IDLE;
            end
          end
        end
        S_REPLY: begin
          if (res_free) begin
            res_vld_q <= 1'b1;
            res_q     <= '{status: ST_IDLE, tag: '0, last: 1'b1};
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // an accepted enqueue adds exactly one valid entry
  a_enq_fills_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> $countones(valid_q) == $past($countones(valid_q)) + 1)
    else $error("enqueue did not add one entry");

  // the entry taken out at the end of a pass was valid
  a_release_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN && flushed && best_found_q) |-> valid_q[best_slot_q])
    else $error("released entry not valid");

  // anything other than a release closes the item
  a_non_release_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && res_q.status != ST_RELEASED) |-> res_q.last)
    else $error("non-release result without last flag");

  // time only moves forward by one
  a_time_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_q != $past(cur_q)) |-> (cur_q == $past(cur_q) + 1'b1))
    else $error("time counter jumped");

endmodule

>>> rtl/terq_out_q.sv
// ----------------------------------------------------------------------------
// terq_out_q
// Short result queue between the engine and the result port.
// ----------------------------------------------------------------------------
module terq_out_q import terq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic res_push_i,
  input  res_t res_i,
  output logic res_full_o,
  input  logic pop_i,
  output logic empty_o,
  output res_t res_o
);

  localparam int PTR_W = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;
  localparam int CNT_W = $clog2(RES_DEPTH + 1);

  res_t             fifo_q [RES_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign res_full_o = (cnt_q == CNT_W'(RES_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign res_o      = fifo_q[rd_ptr_q];
  assign do_push    = res_push_i && !res_full_o;
  assign do_pop     = pop_i && !empty_o;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(RES_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) fifo_q[wr_ptr_q] <= res_i;
  end

endmodule

>>> rtl/timed_event_release_queue.sv
// ----------------------------------------------------------------------------
// timed_event_release_queue
// Store of timed events released in due order on each tick.
//
// Input side is a queue: drive action/delay/tag with push; the item is taken
// on a clock edge with push high and full low. Actions: enqueue, tick, clear.
// Result side is a queue too: while empty is low the oldest result sits on
// status/released_tag/last_result and leaves on an edge with pop high.
// Each input item yields one result, or one per released event on a tick,
// with last_result set on the final one.
//
// Enqueue uses a two-step free slot search over groups of 8 slots. A tick
// scans the whole entry memory once per released event, plus one final scan
// that finds none due; each scan reads one entry per cycle through a 3-stage
// compare pipeline.
// Reset clears the time counter, sequence counter and all valid bits; no
// memory clearing pass is needed. A stalled receiver fills the result queue,
// which then holds the engine; the command queue keeps taking items until
// it is full too.
// ----------------------------------------------------------------------------
module timed_event_release_queue import terq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [1:0]            action_i,
  input  logic [DELAY_W-1:0]    delay_ticks_i,
  input  logic [TAG_PORT_W-1:0] payload_tag_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [1:0]            status_o,
  output logic [TAG_PORT_W-1:0] released_tag_o,
  output logic                  last_result_o
);

  cmd_t cmd;
  logic cmd_valid, cmd_pop;
  res_t eng_res, out_res;
  logic res_push, res_full;

  // front: decode and queue commands
  terq_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .action_i      (action_i),
    .delay_ticks_i (delay_ticks_i),
    .payload_tag_i (payload_tag_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  // back: event store and release sequencer
  terq_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_push_o  (res_push),
    .res_o       (eng_res),
    .res_full_i  (res_full)
  );

  // result queue decouples engine from the receiver
  terq_out_q u_out_q (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_push_i (res_push),
    .res_i      (eng_res),
    .res_full_o (res_full),
    .pop_i      (pop),
    .empty_o    (empty),
    .res_o      (out_res)
  );

  assign status_o       = out_res.status;
  assign released_tag_o = out_res.tag;
  assign last_result_o  = out_res.last;

endmodule

>>> tb/terq_due_order_check.sv
// ----------------------------------------------------------------------------
// terq_due_order_check
// Watches both queues of the timed event release queue, predicts and compares.
//
// Every item taken on the input side runs through a local model of the event
// store. The results it must cause are kept in order and each result taken on
// the output side is checked field by field against the oldest one.
// ----------------------------------------------------------------------------
module terq_due_order_check import terq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic                  full_i,
  input  logic [1:0]            action_i,
  input  logic [DELAY_W-1:0]    delay_ticks_i,
  input  logic [TAG_PORT_W-1:0] payload_tag_i,
  input  logic                  empty_i,
  input  logic                  pop_i,
  input  logic [1:0]            status_i,
  input  logic [TAG_PORT_W-1:0] released_tag_i,
  input  logic                  last_result_i,
  output int                    errors_o,
  output int                    pending_o,
  output int                    results_o,
  output int                    released_o,
  output int                    rejected_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_e               status;
    logic [TAG_PORT_W-1:0] tag;
    logic                  last;
  } outcome_t;

  // model of the event store
  logic [TIME_W-1:0]      now_q;
  logic [TIME_W-1:0]      seq_q;
  logic [TIME_W-1:0]      due_mem   [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]    tag_mem   [QUEUE_DEPTH];
  logic [TIME_W-1:0]      order_mem [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] live_q;

  outcome_t due_results_q[$];
  outcome_t want;

  function automatic outcome_t make_outcome(input status_e st,
                                            input logic [TAG_PORT_W-1:0] tag,
                                            input logic last);
    outcome_t o;
    o.status = st;
    o.tag    = tag;
    o.last   = last;
    return o;
  endfunction

  // append one predicted result at the tail
  function automatic void add_outcome(input outcome_t o);
    due_results_q = {due_results_q, o};
  endfunction

  // Slot of the most overdue live entry, oldest enqueue on a tie; -1 if none.
  // Lateness is a modular distance: the top bit set means not yet due.
  function automatic int earliest_due();
    int                best;
    logic [TIME_W-1:0] late;
    logic [TIME_W-1:0] age;
    logic [TIME_W-1:0] best_late;
    logic [TIME_W-1:0] best_age;
    best      = -1;
    best_late = '0;
    best_age  = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (!live_q[i]) continue;
      late = now_q - due_mem[i];
      if (late[TIME_W-1]) continue;
      age = seq_q - order_mem[i];
      if (best < 0 || late > best_late || (late == best_late && age > best_age)) begin
        best      = i;
        best_late = late;
        best_age  = age;
      end
    end
    return best;
  endfunction

  task automatic apply_item(input logic [1:0] act, input logic [DELAY_W-1:0] dly,
                            input logic [TAG_PORT_W-1:0] tag);
    int       slot;
    int       pick;
    outcome_t held;
    logic     have_held;
    slot      = -1;
    have_held = 1'b0;
    held      = '0;
    case (act)
      ACT_ENQUEUE: begin
        // lowest free slot
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
          if (!live_q[i]) slot = i;
        if (slot < 0) begin
          add_outcome(make_outcome(ST_FULL, '0, 1'b1));
          rejected_o++;
        end else begin
          live_q[slot]    = 1'b1;
          due_mem[slot]   = now_q + TIME_W'(dly);
          tag_mem[slot]   = tag[TAG_BITS-1:0];
          order_mem[slot] = seq_q;
          seq_q           = seq_q + 1'b1;
          add_outcome(make_outcome(ST_ACCEPTED, '0, 1'b1));
        end
      end
      ACT_TICK: begin
        now_q = now_q + 1'b1;
        pick  = earliest_due();
        // hold one release back so the final one can carry the last flag
        while (pick >= 0) begin
          live_q[pick] = 1'b0;
          if (have_held) add_outcome(held);
          held      = make_outcome(ST_RELEASED, TAG_PORT_W'(tag_mem[pick]), 1'b0);
          have_held = 1'b1;
          released_o++;
          pick = earliest_due();
        end
        if (have_held) begin
          held.last = 1'b1;
          add_outcome(held);
        end else begin
          add_outcome(make_outcome(ST_IDLE, '0, 1'b1));
        end
      end
      ACT_CLEAR: begin
        live_q = '0;
        add_outcome(make_outcome(ST_IDLE, '0, 1'b1));
      end
      default: begin
        add_outcome(make_outcome(ST_IDLE, '0, 1'b1));
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q  = '0;
      seq_q  = '0;
      live_q = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        due_mem[i]   = '0;
        tag_mem[i]   = '0;
        order_mem[i] = '0;
      end
      due_results_q.delete();
      pending_o <= 0;
    end else begin
      if (push_i && !full_i) apply_item(action_i, delay_ticks_i, payload_tag_i);
      if (pop_i && !empty_i) begin
        results_o++;
        if (due_results_q.size() == 0) begin
          errors_o++;
          $error("unexpected result: status %0d tag %0h last %0b",
                 status_i, released_tag_i, last_result_i);
        end else begin
          want = due_results_q.pop_front();
          if (status_i !== want.status) begin
            errors_o++;
            $error("status: expected %0d, got %0d", want.status, status_i);
          end
          if (released_tag_i !== want.tag) begin
            errors_o++;
            $error("released_tag: expected %0h, got %0h", want.tag, released_tag_i);
          end
          if (last_result_i !== want.last) begin
            errors_o++;
            $error("last_result: expected %0b, got %0b", want.last, last_result_i);
          end
        end
      end
      pending_o <= due_results_q.size();
    end
  end

endmodule

>>> tb/tb_timed_event_release_queue.sv
// ----------------------------------------------------------------------------
// tb_timed_event_release_queue
// Self-checking testbench for the timed event release queue.
//
// A short directed run covers idle ticks, an undefined action, zero and
// maximum delays, due-time ordering with ties, and clearing. A random run of
// short enqueue/tick bursts, store fills, long delays, clears and noise
// follows, with random gaps on the input and random stalls on the output.
// A separate checker predicts every result and compares it.
// ----------------------------------------------------------------------------
module tb_timed_event_release_queue import terq_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int         HALF_PERIOD = 2;
  localparam int         ITEMS_TOTAL = 200;   // random part stops after this many
  localparam int         QUIET_FROM  = 170;   // no gaps or stalls from here on
  localparam int         IDLE_LIMIT  = 4000;  // cycles with no transfer at all
  localparam int         DRAIN_WAIT  = 200;   // wait once nothing is pending
  localparam logic [1:0] ACT_UNDEF   = 2'd3;  // action code with no meaning

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  push;
  logic                  full;
  logic [1:0]            action_i;
  logic [DELAY_W-1:0]    delay_ticks_i;
  logic [TAG_PORT_W-1:0] payload_tag_i;
  logic                  empty;
  logic                  pop;
  logic [1:0]            status_o;
  logic [TAG_PORT_W-1:0] released_tag_o;
  logic                  last_result_o;

  int   errors;
  int   pending;
  int   results;
  int   released;
  int   rejected;
  int   items_sent;
  int   idle_cycles;
  logic idling = 1'b1;

  always #HALF_PERIOD clk_i = ~clk_i;

  timed_event_release_queue dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .action_i       (action_i),
    .delay_ticks_i  (delay_ticks_i),
    .payload_tag_i  (payload_tag_i),
    .empty          (empty),
    .pop            (pop),
    .status_o       (status_o),
    .released_tag_o (released_tag_o),
    .last_result_o  (last_result_o)
  );

  terq_due_order_check u_due_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_i         (full),
    .action_i       (action_i),
    .delay_ticks_i  (delay_ticks_i),
    .payload_tag_i  (payload_tag_i),
    .empty_i        (empty),
    .pop_i          (pop),
    .status_i       (status_o),
    .released_tag_i (released_tag_o),
    .last_result_i  (last_result_o),
    .errors_o       (errors),
    .pending_o      (pending),
    .results_o      (results),
    .released_o     (released),
    .rejected_o     (rejected)
  );

  // Offer one item, maybe after a random gap, and hold it until taken.
  // full is read right after the edge, so it is the value the edge saw.
  task automatic send_item(input logic [1:0] act, input logic [DELAY_W-1:0] dly,
                           input logic [TAG_PORT_W-1:0] tag);
    if (idling && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    push          <= 1'b1;
    action_i      <= act;
    delay_ticks_i <= dly;
    payload_tag_i <= tag;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    items_sent++;
  endtask

  // Receiver: long runs of pop high, broken by stall bursts while idling.
  initial begin
    @(posedge rst_ni);
    forever begin
      if (idling && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end else begin
        pop <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  // Watchdog: a tick scans the whole store once per release, so gaps with no
  // transfer are normal during a tick; a gap that reaches IDLE_LIMIT means a hang.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("** timed_event_release_queue: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    int pick;
    int n;
    logic first_burst;
    idle_cycles    = 0;
    items_sent     = 0;
    first_burst    = 1'b1;
    rst_ni        <= 1'b0;
    push          <= 1'b0;
    pop           <= 1'b0;
    action_i      <= ACT_ENQUEUE;
    delay_ticks_i <= '0;
    payload_tag_i <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed part ----
    // tick on an empty store, then an undefined action: both report idle
    send_item(ACT_TICK, '0, '0);
    send_item(ACT_UNDEF, '1, '1);
    // zero delay: stored only, leaves on the very next tick
    send_item(ACT_ENQUEUE, '0, 16'hFFFF);
    send_item(ACT_TICK, '0, '0);
    // ordering: the overdue one first, then a tie in enqueue order
    send_item(ACT_ENQUEUE, 24'd2, 16'h0001);
    send_item(ACT_ENQUEUE, 24'd1, 16'h0002);
    send_item(ACT_ENQUEUE, 24'd1, 16'h0003);
    send_item(ACT_ENQUEUE, 24'd0, 16'h0004);
    send_item(ACT_TICK, '0, '0);
    send_item(ACT_TICK, '0, '0);
    // far-future events are dropped by clear, never released
    send_item(ACT_ENQUEUE, 24'hFFFFFF, 16'hAAAA);
    send_item(ACT_ENQUEUE, 24'h800000, 16'h5555);
    send_item(ACT_CLEAR, '0, '0);
    send_item(ACT_TICK, '0, '0);
    // delay two: nothing on the first tick, released on the second
    send_item(ACT_ENQUEUE, 24'd2, 16'h0000);
    send_item(ACT_TICK, '0, '0);
    send_item(ACT_TICK, '0, '0);

    // ---- random part ----
    while (items_sent < ITEMS_TOTAL) begin
      if (items_sent >= QUIET_FROM) idling = 1'b0;
      pick        = first_burst ? 0 : $urandom_range(0, 15);
      first_burst = 1'b0;
      if (pick == 0) begin
        // fill the store past its depth, then a few ticks release all of it
        send_item(ACT_CLEAR, '0, '0);
        for (int i = 0; i < QUEUE_DEPTH + 2; i++)
          send_item(ACT_ENQUEUE, DELAY_W'($urandom_range(0, 1)), TAG_PORT_W'($urandom));
        repeat (3) send_item(ACT_TICK, '0, '0);
      end else if (pick <= 9) begin
        // well-formed burst: a few near events, then ticks that release those due
        n = $urandom_range(1, 8);
        repeat (n)
          send_item(ACT_ENQUEUE, DELAY_W'($urandom_range(0, 5)), TAG_PORT_W'($urandom));
        n = $urandom_range(1, 7);
        repeat (n) send_item(ACT_TICK, '0, '0);
      end else if (pick <= 11) begin
        // long random delays: nearly all stay stored until the clear
        n = $urandom_range(1, 3);
        repeat (n) send_item(ACT_ENQUEUE, DELAY_W'($urandom), TAG_PORT_W'($urandom));
        send_item(ACT_ENQUEUE, '1, TAG_PORT_W'($urandom));
        send_item(ACT_TICK, '0, '0);
        send_item(ACT_CLEAR, '0, '0);
      end else if (pick <= 13) begin
        // noise: any action code, any field value
        n = $urandom_range(1, 4);
        repeat (n)
          send_item(2'($urandom_range(0, 3)), DELAY_W'($urandom), TAG_PORT_W'($urandom));
      end else if (pick == 14) begin
        send_item(ACT_CLEAR, DELAY_W'($urandom), TAG_PORT_W'($urandom));
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) send_item(ACT_TICK, DELAY_W'($urandom), TAG_PORT_W'($urandom));
      end
    end
    push <= 1'b0;

    // one edge so the checker has counted the last item, then drain
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Covered %0d items and %0d results: %0d events released, %0d enqueues refused",
             items_sent, results, released, rejected);
    $display("on a full store, with random gaps and stalls on both sides.");
    if (errors == 0 && pending == 0) begin
      $display("** timed_event_release_queue: PASSED **");
    end else begin
      $display("** timed_event_release_queue: FAILED **");
    end
    $finish;
  end

endmodule

>>> timed_event_release_queue.f
rtl/terq_pkg.sv
rtl/terq_front.sv
rtl/terq_engine.sv
rtl/terq_out_q.sv
rtl/timed_event_release_queue.sv
tb/terq_due_order_check.sv
tb/tb_timed_event_release_queue.sv
